>>> src/tamavg_pkg.sv
// shared widths, register codes and control types for the three-axis moving average
package tamavg_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int VAL_W     = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_AXES  = 3;
  localparam int GAIN_FRAC = 8;

  localparam logic [CFG_IDX_W-1:0] REG_Z_OFFSET   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Z_GAIN_POS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Z_GAIN_NEG = 2'd2;

  localparam logic [CFG_W-1:0] Z_OFFSET_RST   = 16'd75;
  localparam logic [CFG_W-1:0] Z_GAIN_POS_RST = 16'd90;
  localparam logic [CFG_W-1:0] Z_GAIN_NEG_RST = 16'd371;

  typedef struct packed {
    logic ld_in;
    logic ld_mul;
    logic ld_rnd;
  } zconv_ctl_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic ld_abs;
    logic ld_mul;
    logic ld_fix;
    logic ld_mean;
  } lane_ctl_t;

endpackage

>>> src/three_axis_moving_average.sv
// Three-axis boxcar moving average, top level.
//
// Input stream s_axis carries one word per sample set: x, y and raw z. Output
// stream m_axis returns one word per accepted input with the three rounded
// window means. Both sides use tvalid/tready; a word moves when both are high.
// The cfg channel writes z_offset (index 0), z_gain_pos (1) and z_gain_neg (2);
// cfg_ready_o is always high and other indexes are dropped. Write it only when
// the pipeline is empty.
// Throughput is one word per cycle while m_axis_tready is high, set by the single
// read port and single write port of each window memory, both used once per word.
// Each stage holds its own valid bit, so bubbles collapse while m_axis_tready
// is low; s_axis_tready drops only when all ten stages are full.
// Reset restores the register defaults and marks every window entry as empty,
// so empty entries count as zero at once with no clearing pass.
module three_axis_moving_average #(
  parameter int WINDOW = 35
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // x_sample, y_sample, z_sample
  input  logic [3*tamavg_pkg::SAMPLE_W-1:0]     s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // x_mean, y_mean, z_mean
  output logic [3*tamavg_pkg::VAL_W-1:0]        m_axis_tdata,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [tamavg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tamavg_pkg::CFG_W-1:0]          cfg_data_i
);
  import tamavg_pkg::*;

  localparam int SW     = $clog2(WINDOW);
  localparam int NUM_ST = 10;
  localparam int ST_IN   = 0;
  localparam int ST_MUL  = 1;
  localparam int ST_RND  = 2;
  localparam int ST_RD   = 3;
  localparam int ST_SUM  = 4;
  localparam int ST_ABS  = 5;
  localparam int ST_PRD  = 6;
  localparam int ST_FIX  = 7;
  localparam int ST_MEAN = 8;
  localparam int ST_OUT  = 9;
  localparam logic signed [SAMPLE_W-1:0] S_HI = SAMPLE_W'(32'sd32767);
  localparam logic signed [SAMPLE_W-1:0] S_LO = SAMPLE_W'(-32'sd32768);

  function automatic logic [VAL_W-1:0] sat16(input logic signed [SAMPLE_W-1:0] v);
    logic [VAL_W-1:0] r;
    if (v > S_HI) begin
      r = VAL_W'(S_HI);
    end else if (v < S_LO) begin
      r = VAL_W'(S_LO);
    end else begin
      r = VAL_W'(v);
    end
    return r;
  endfunction

  logic [NUM_ST-1:0] st_v_q, st_v_d, st_rdy, st_ld;

  logic [CFG_W-1:0] z_offset_q, z_gain_pos_q, z_gain_neg_q;

  logic [SAMPLE_W-1:0] xr_q, yr_q;
  logic [VAL_W-1:0]    xc_q, yc_q, xd_q, yd_q;
  logic [VAL_W-1:0]    z_val;

  logic [SW-1:0]       rd_slot_q, wr_slot_q;
  logic [WINDOW-1:0]   vld_q;
  logic                old_vld_q;

  logic [VAL_W-1:0]    lane_val  [NUM_AXES];
  logic [VAL_W-1:0]    lane_mean [NUM_AXES];
  logic [VAL_W-1:0]    out_q     [NUM_AXES];

  zconv_ctl_t zctl;
  lane_ctl_t  lctl;

  // stage handshake, each stage moves when the next one is free
  always_comb begin
    st_rdy[NUM_ST-1] = !st_v_q[NUM_ST-1] || m_axis_tready;
    for (int k = NUM_ST - 2; k >= 0; k--) begin
      st_rdy[k] = !st_v_q[k] || st_rdy[k+1];
    end
    st_ld[0]  = s_axis_tvalid && st_rdy[0];
    st_v_d[0] = st_rdy[0] ? s_axis_tvalid : st_v_q[0];
    for (int k = 1; k < NUM_ST; k++) begin
      st_ld[k]  = st_v_q[k-1] && st_rdy[k];
      st_v_d[k] = st_rdy[k] ? st_v_q[k-1] : st_v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_v_q <= '0;
    end else begin
      st_v_q <= st_v_d;
    end
  end

  assign s_axis_tready = st_rdy[ST_IN];
  assign m_axis_tvalid = st_v_q[ST_OUT];

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z_offset_q   <= Z_OFFSET_RST;
      z_gain_pos_q <= Z_GAIN_POS_RST;
      z_gain_neg_q <= Z_GAIN_NEG_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_Z_OFFSET:   z_offset_q   <= cfg_data_i;
        REG_Z_GAIN_POS: z_gain_pos_q <= cfg_data_i;
        REG_Z_GAIN_NEG: z_gain_neg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // x and y front end, delayed to line up with z
  always_ff @(posedge clk_i) begin
    if (st_ld[ST_IN]) begin
      xr_q <= s_axis_tdata[SAMPLE_W-1:0];
      yr_q <= s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
    end
    if (st_ld[ST_MUL]) begin
      xc_q <= sat16(xr_q);
      yc_q <= sat16(yr_q);
    end
    if (st_ld[ST_RND]) begin
      xd_q <= xc_q;
      yd_q <= yc_q;
    end
  end

  assign zctl.ld_in  = st_ld[ST_IN];
  assign zctl.ld_mul = st_ld[ST_MUL];
  assign zctl.ld_rnd = st_ld[ST_RND];

  tamavg_zconv u_zconv (
    .clk_i        (clk_i),
    .ctl_i        (zctl),
    .z_sample_i   (s_axis_tdata[3*SAMPLE_W-1:2*SAMPLE_W]),
    .z_offset_i   (z_offset_q),
    .z_gain_pos_i (z_gain_pos_q),
    .z_gain_neg_i (z_gain_neg_q),
    .z_val_o      (z_val)
  );

  // window slot pointer and entry valid bits, shared by all lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_slot_q <= '0;
      wr_slot_q <= '0;
      vld_q     <= '0;
      old_vld_q <= 1'b0;
    end else begin
      if (st_ld[ST_RD]) begin
        wr_slot_q <= rd_slot_q;
        old_vld_q <= vld_q[rd_slot_q];
        if (rd_slot_q == SW'(WINDOW - 1)) begin
          rd_slot_q <= '0;
        end else begin
          rd_slot_q <= rd_slot_q + SW'(1);
        end
      end
      if (st_ld[ST_SUM]) begin
        vld_q[wr_slot_q] <= 1'b1;
      end
    end
  end

  assign lctl.rd      = st_ld[ST_RD];
  assign lctl.wr      = st_ld[ST_SUM];
  assign lctl.ld_abs  = st_ld[ST_ABS];
  assign lctl.ld_mul  = st_ld[ST_PRD];
  assign lctl.ld_fix  = st_ld[ST_FIX];
  assign lctl.ld_mean = st_ld[ST_MEAN];

  assign lane_val[0] = xd_q;
  assign lane_val[1] = yd_q;
  assign lane_val[2] = z_val;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    tamavg_lane #(
      .WINDOW (WINDOW)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (lctl),
      .rd_slot_i (rd_slot_q),
      .wr_slot_i (wr_slot_q),
      .old_vld_i (old_vld_q),
      .val_i     (lane_val[a]),
      .mean_o    (lane_mean[a])
    );
  end

  // merge the lane means into one output word
  always_ff @(posedge clk_i) begin
    if (st_ld[ST_OUT]) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        out_q[a] <= lane_mean[a];
      end
    end
  end

  assign m_axis_tdata = {out_q[2], out_q[1], out_q[0]};

endmodule

>>> src/tamavg_zconv.sv
// z axis front end: offset, signed gain select, q8.8 rounding and saturation
module tamavg_zconv (
  input  logic                               clk_i,
  input  tamavg_pkg::zconv_ctl_t             ctl_i,
  input  logic [tamavg_pkg::SAMPLE_W-1:0]    z_sample_i,
  input  logic [tamavg_pkg::CFG_W-1:0]       z_offset_i,
  input  logic [tamavg_pkg::CFG_W-1:0]       z_gain_pos_i,
  input  logic [tamavg_pkg::CFG_W-1:0]       z_gain_neg_i,
  output logic [tamavg_pkg::VAL_W-1:0]       z_val_o
);
  import tamavg_pkg::*;

  localparam int SH_W = SAMPLE_W + 1;
  localparam int PR_W = SH_W + CFG_W + 1;
  localparam logic signed [PR_W-1:0] VAL_HI = PR_W'(32'sd32767);
  localparam logic signed [PR_W-1:0] VAL_LO = PR_W'(-32'sd32768);

  logic signed [SH_W-1:0] sh_d, sh_q;
  logic [CFG_W-1:0]       gain_d, gain_q;
  logic signed [PR_W-1:0] prod_d, prod_q;
  logic signed [PR_W-1:0] bias, biased, rnd;
  logic [VAL_W-1:0]       val_d, val_q;

  assign sh_d   = $signed({z_sample_i[SAMPLE_W-1], z_sample_i}) - SH_W'($signed(z_offset_i));
  assign gain_d = ($signed(z_sample_i) > $signed(z_offset_i)) ? z_gain_pos_i : z_gain_neg_i;

  assign prod_d = sh_q * $signed({1'b0, gain_q});

  // half away from zero: negative side rounds with one less
  assign bias   = prod_q[PR_W-1] ? PR_W'(127) : PR_W'(128);
  assign biased = prod_q + bias;
  assign rnd    = biased >>> GAIN_FRAC;

  always_comb begin
    if (rnd > VAL_HI) begin
      val_d = VAL_W'(VAL_HI);
    end else if (rnd < VAL_LO) begin
      val_d = VAL_W'(VAL_LO);
    end else begin
      val_d = VAL_W'(rnd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_in) begin
      sh_q   <= sh_d;
      gain_q <= gain_d;
    end
    if (ctl_i.ld_mul) begin
      prod_q <= prod_d;
    end
    if (ctl_i.ld_rnd) begin
      val_q <= val_d;
    end
  end

  assign z_val_o = val_q;

endmodule

>>> src/tamavg_lane.sv
// one axis lane: window memory, running total and rounded division by the window length
module tamavg_lane #(
  parameter int WINDOW = 35
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tamavg_pkg::lane_ctl_t         ctl_i,
  input  logic [$clog2(WINDOW)-1:0]     rd_slot_i,
  input  logic [$clog2(WINDOW)-1:0]     wr_slot_i,
  input  logic                          old_vld_i,
  input  logic [tamavg_pkg::VAL_W-1:0]  val_i,
  output logic [tamavg_pkg::VAL_W-1:0]  mean_o
);
  import tamavg_pkg::*;

  localparam int TW = $clog2(WINDOW) + VAL_W;
  localparam int NW = TW + 1;
  localparam int MW = NW;
  localparam int QW = VAL_W + 1;
  localparam int D  = 2 * WINDOW;
  localparam int RW = $clog2(2 * D);
  localparam logic [MW-1:0] RECIP = MW'((64'd1 << NW) / D);

  logic [VAL_W-1:0]   win_mem [WINDOW];
  logic [VAL_W-1:0]   nv_q, rdat_q, old_val;
  logic [TW-1:0]      tot_d, tot_q;
  logic [NW:0]        t2, n_full;
  logic [NW-1:0]      n_d, n_q, n7_q;
  logic               neg_q, neg7_q, neg8_q;
  logic [NW+MW-1:0]   prod_d, prod_q;
  logic [QW-1:0]      q0_d, q0_q, q;
  logic [NW-1:0]      r_full;
  logic [RW-1:0]      r_q;
  logic [VAL_W-1:0]   mean_d, mean_q;

  assign old_val = old_vld_i ? rdat_q : '0;

  assign tot_d = tot_q
               + {{(TW-VAL_W){nv_q[VAL_W-1]}}, nv_q}
               - {{(TW-VAL_W){old_val[VAL_W-1]}}, old_val};

  // 2*|t| + window in one add or subtract
  assign t2     = {tot_q[TW-1], tot_q, 1'b0};
  assign n_full = tot_q[TW-1] ? ((NW+1)'(WINDOW) - t2) : (t2 + (NW+1)'(WINDOW));
  assign n_d    = n_full[NW-1:0];

  assign prod_d = (NW+MW)'(n_q) * (NW+MW)'(RECIP);
  assign q0_d   = prod_q[NW +: QW];
  assign r_full = n7_q - NW'(q0_d * D);

  assign q      = q0_q + QW'(r_q >= RW'(D));
  assign mean_d = neg8_q ? VAL_W'(-q) : VAL_W'(q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      win_mem[wr_slot_i] <= nv_q;
    end
    if (ctl_i.rd) begin
      rdat_q <= win_mem[rd_slot_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd) begin
      nv_q <= val_i;
    end
    if (ctl_i.ld_abs) begin
      n_q   <= n_d;
      neg_q <= tot_q[TW-1];
    end
    if (ctl_i.ld_mul) begin
      prod_q <= prod_d;
      n7_q   <= n_q;
      neg7_q <= neg_q;
    end
    if (ctl_i.ld_fix) begin
      q0_q   <= q0_d;
      r_q    <= r_full[RW-1:0];
      neg8_q <= neg7_q;
    end
    if (ctl_i.ld_mean) begin
      mean_q <= mean_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q <= '0;
    end else if (ctl_i.wr) begin
      tot_q <= tot_d;
    end
  end

  assign mean_o = mean_q;

endmodule

>>> sim/three_axis_moving_average_tb.sv
// self-checking testbench for the three-axis moving average with its own window predictor
`timescale 1ns / 100ps

module three_axis_moving_average_tb;
  import tamavg_pkg::*;

  localparam int WIN = 35;
  localparam int N_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 157;
  localparam int MAX_REPORTS = 10;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [VAL_W-1:0] val_t;
  typedef struct packed {
    val_t z;
    val_t y;
    val_t x;
  } means_t;
  typedef struct {
    sample_t x;
    sample_t y;
    sample_t z;
    bit      pin;
    means_t  want;
  } dir_row_t;

  localparam sample_t SMAX = 24'sh7fffff;
  localparam sample_t SMIN = -24'sh800000;
  localparam sample_t Z_ZERO = sample_t'(Z_OFFSET_RST);

  logic                        clk_i;
  logic                        rst_ni;
  logic                        s_axis_tvalid;
  logic                        s_axis_tready;
  // x_sample, y_sample, z_sample
  logic [3*SAMPLE_W-1:0]       s_axis_tdata;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready;
  // x_mean, y_mean, z_mean
  logic [3*VAL_W-1:0]          m_axis_tdata;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [CFG_IDX_W-1:0]        cfg_index_i;
  logic [CFG_W-1:0]            cfg_data_i;

  three_axis_moving_average #(
    .WINDOW(WIN)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  logic signed [CFG_W-1:0] z_off;
  logic [CFG_W-1:0]        gain_pos;
  logic [CFG_W-1:0]        gain_neg;
  val_t                    hist [NUM_AXES][WIN];
  longint                  sums [NUM_AXES];
  int                      head;

  means_t   means_q [$];
  dir_row_t dir_rows [$];
  bit       row_pinned;
  means_t   row_want;
  means_t   fresh_means;
  int       send_idle;
  int       recv_idle;
  int       fails;
  int       n_samples;
  int       n_means;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(5_000_000);
    $display("== FAIL ==");
    $finish;
  end

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint div_half_away(longint n, longint d);
    longint mag;
    mag = (n < 0) ? -n : n;
    mag = (2 * mag + d) / (2 * d);
    return (n < 0) ? -mag : mag;
  endfunction

  function automatic longint scale_z(longint raw);
    longint shifted;
    longint gain;
    shifted = raw - longint'(z_off);
    gain = (shifted > 0) ? longint'(gain_pos) : longint'(gain_neg);
    return sat16(div_half_away(shifted * gain, longint'(1) << GAIN_FRAC));
  endfunction

  function automatic means_t advance_window(input logic [3*SAMPLE_W-1:0] word);
    longint fresh [NUM_AXES];
    means_t res;
    int a;
    fresh[0] = sat16(longint'($signed(word[SAMPLE_W-1:0])));
    fresh[1] = sat16(longint'($signed(word[2*SAMPLE_W-1:SAMPLE_W])));
    fresh[2] = scale_z(longint'($signed(word[3*SAMPLE_W-1:2*SAMPLE_W])));
    for (a = 0; a < NUM_AXES; a++) begin
      sums[a] += fresh[a] - longint'(hist[a][head]);
      hist[a][head] = val_t'(fresh[a]);
    end
    head = (head == WIN - 1) ? 0 : head + 1;
    res.x = val_t'(div_half_away(sums[0], WIN));
    res.y = val_t'(div_half_away(sums[1], WIN));
    res.z = val_t'(div_half_away(sums[2], WIN));
    return res;
  endfunction

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    case (idx)
      REG_Z_OFFSET: begin
        z_off = val;
      end
      REG_Z_GAIN_POS: begin
        gain_pos = val;
      end
      REG_Z_GAIN_NEG: begin
        gain_neg = val;
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_means(input logic [3*VAL_W-1:0] word);
    means_t seen;
    means_t want;
    seen = word;
    n_means++;
    if (means_q.size() == 0) begin
      fails++;
      if (fails <= MAX_REPORTS) $display("unexpected result word %h", word);
    end else begin
      want = means_q.pop_front();
      if (seen.x != want.x || seen.y != want.y || seen.z != want.z) begin
        fails++;
        if (fails <= MAX_REPORTS) begin
          $display("mismatch at result %0d: x exp %0d got %0d, y exp %0d got %0d, z exp %0d got %0d",
                   n_means, want.x, seen.x, want.y, seen.y, want.z, seen.z);
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) apply_reg(cfg_index_i, cfg_data_i);
      if (m_axis_tvalid && m_axis_tready) check_means(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) begin
        n_samples++;
        fresh_means = advance_window(s_axis_tdata);
        means_q.push_back(row_pinned ? row_want : fresh_means);
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic push_sample(input sample_t x, input sample_t y, input sample_t z,
                             input bit pin, input means_t want);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    row_pinned    <= pin;
    row_want      <= want;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (means_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic add_row(input sample_t x, input sample_t y, input sample_t z, input bit pin,
                         input int wx, input int wy, input int wz);
    dir_row_t r;
    r.x = x;
    r.y = y;
    r.z = z;
    r.pin = pin;
    r.want.x = val_t'(wx);
    r.want.y = val_t'(wy);
    r.want.z = val_t'(wz);
    dir_rows.push_back(r);
  endtask

  function automatic sample_t rand_axis(input logic signed [CFG_W-1:0] center);
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) return sample_t'($urandom);
    if (pick < 75) return sample_t'(longint'(center) + int'($urandom_range(80000)) - 40000);
    if (pick < 88) return sample_t'(longint'(center) + int'($urandom_range(600)) - 300);
    case ($urandom_range(3))
      0: return SMAX;
      1: return SMIN;
      2: return sample_t'(32767 + int'($urandom_range(2)));
      default: return sample_t'(-32767 - int'($urandom_range(2)));
    endcase
  endfunction

  initial begin
    int ph;
    int i;
    int run_left;
    sample_t rx;
    sample_t ry;
    sample_t rz;
    means_t none;

    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_Z_OFFSET;
    cfg_data_i = '0;
    row_pinned = 1'b0;
    row_want = '0;
    none = '0;
    send_idle = 0;
    recv_idle = 0;
    fails = 0;
    n_samples = 0;
    n_means = 0;
    run_left = 0;
    rx = '0;
    ry = '0;
    rz = '0;
    z_off = Z_OFFSET_RST;
    gain_pos = Z_GAIN_POS_RST;
    gain_neg = Z_GAIN_NEG_RST;
    head = 0;
    for (i = 0; i < NUM_AXES; i++) sums[i] = 0;
    for (i = 0; i < WIN; i++) begin
      hist[0][i] = '0;
      hist[1][i] = '0;
      hist[2][i] = '0;
    end

    // window starts empty, so the first means are easy to read off
    add_row(0, 0, Z_ZERO, 1'b1, 0, 0, 0);
    add_row(35, -35, Z_ZERO, 1'b1, 1, -1, 0);
    add_row(SMAX, SMIN, Z_ZERO, 1'b1, 937, -937, 0);
    add_row(32767, -32768, SMAX, 1'b0, 0, 0, 0);
    add_row(32768, -32769, SMIN, 1'b0, 0, 0, 0);
    add_row(-32768, 32767, sample_t'(Z_ZERO + 1), 1'b0, 0, 0, 0);
    add_row(-32769, 32768, sample_t'(Z_ZERO - 1), 1'b0, 0, 0, 0);
    add_row(1, -1, sample_t'(Z_ZERO + 64), 1'b0, 0, 0, 0);
    add_row(-1, 1, sample_t'(Z_ZERO - 64), 1'b0, 0, 0, 0);
    add_row(24'h555555, 24'haaaaaa, 24'h555555, 1'b0, 0, 0, 0);
    add_row(24'haaaaaa, 24'h555555, 24'haaaaaa, 1'b0, 0, 0, 0);
    add_row(17, -17, Z_ZERO, 1'b0, 0, 0, 0);
    add_row(-18, 18, 24'h00ffff, 1'b0, 0, 0, 0);
    add_row(24'hff0000, 24'h00ff00, 24'hff00ff, 1'b0, 0, 0, 0);

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (ph = 0; ph < N_PHASES; ph++) begin
      if (ph < 2) begin
        send_idle = 11;
        recv_idle = 78;
      end else if (ph < 4) begin
        send_idle = 78;
        recv_idle = 11;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end

      case (ph)
        1: begin
          write_reg(REG_Z_OFFSET, 16'h8000);
          write_reg(REG_Z_GAIN_POS, 16'h0000);
          write_reg(REG_Z_GAIN_NEG, 16'hffff);
        end
        2: begin
          write_reg(REG_Z_OFFSET, 16'h7fff);
          write_reg(REG_Z_GAIN_POS, 16'hffff);
          write_reg(REG_Z_GAIN_NEG, 16'h0000);
        end
        3: begin
          // gain of one half makes ties common; the unused index must change nothing
          write_reg(REG_Z_OFFSET, 16'h0000);
          write_reg(REG_Z_GAIN_POS, 16'h0080);
          write_reg(REG_Z_GAIN_NEG, 16'h0080);
          write_reg(REG_UNUSED, 16'($urandom));
        end
        4, 5: begin
          write_reg(REG_Z_OFFSET, 16'($urandom));
          write_reg(REG_Z_GAIN_POS, 16'($urandom));
          write_reg(REG_Z_GAIN_NEG, 16'($urandom_range(1023)));
        end
        default: begin
        end
      endcase
      cfg_valid_i <= 1'b0;

      if (ph == 0) begin
        foreach (dir_rows[k]) begin
          push_sample(dir_rows[k].x, dir_rows[k].y, dir_rows[k].z, dir_rows[k].pin,
                      dir_rows[k].want);
        end
      end

      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i == ITEMS_PER_PHASE / 2) drain();
        // long runs of one extreme fill the window and drive the means to their limits
        if (run_left == 0 && $urandom_range(99) < 2) begin
          run_left = WIN + $urandom_range(10);
          rx = $urandom_range(1) ? SMAX : SMIN;
          ry = $urandom_range(1) ? SMAX : SMIN;
          rz = $urandom_range(1) ? SMAX : SMIN;
        end
        if (run_left > 0) begin
          run_left--;
          push_sample(rx, ry, rz, 1'b0, none);
        end else begin
          push_sample(rand_axis('0), rand_axis('0), rand_axis(z_off), 1'b0, none);
        end
      end
      drain();
    end

    repeat (20) @(negedge clk_i);
    fails += means_q.size();
    $display("covered %0d samples over %0d register settings and three idle patterns",
             n_samples, N_PHASES);
    $display("%0d window means compared, %0d failures", n_means, fails);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
src/tamavg_pkg.sv
src/tamavg_zconv.sv
src/tamavg_lane.sv
src/three_axis_moving_average.sv
sim/three_axis_moving_average_tb.sv
